@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the pulse period speedometer.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/ppspd_pkg.sv @@
// Package of the pulse period speedometer: widths, register codes, reset values
// and the divider control types. Depends on nothing.
package ppspd_pkg;

  localparam int TIMER_BITS = 32;
  localparam int PERIOD_W   = 20;
  localparam int SPEED_W    = 10;
  localparam int TALLY_W    = 8;
  localparam int SCALED_W   = PERIOD_W + 1;
  localparam int DIV_DW     = TIMER_BITS;
  localparam int DIV_VW     = PERIOD_W;
  localparam int DIV_CW     = $clog2(DIV_DW + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_METRIC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPDCON  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 3'd5;

  localparam logic [TALLY_W-1:0]  RST_PULSES  = 8'd10;
  localparam logic [PERIOD_W-1:0] RST_SPDCON  = 20'd877193;
  localparam logic [PERIOD_W-1:0] RST_PLIMIT  = 20'd877200;
  localparam logic [23:0]         RST_STALL   = 24'd1000000;
  localparam logic [SPEED_W-1:0]  RST_CEILING = 10'd999;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
  // 1.60934 in unsigned Q16
  localparam logic [16:0] METRIC_Q16 = 17'd105470;

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/ppspd_if.sv @@
// Valid/ready channel interfaces of the pulse period speedometer.
// Depends on ppspd_pkg for payload widths.
interface ppspd_in_if;
  logic valid;
  logic ready;
  logic pulse_edge;
  modport source (output valid, output pulse_edge, input ready);
  modport sink   (input valid, input pulse_edge, output ready);
endinterface

interface ppspd_out_if import ppspd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_value;
  logic               speed_updated;
  modport source (output valid, output speed_value, output speed_updated, input ready);
  modport sink   (input valid, input speed_value, input speed_updated, output ready);
endinterface

interface ppspd_cfg_if import ppspd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/pulse_period_speedometer.sv @@
// Top level of the pulse period speedometer: counters, speed sequencer, config.
// Depends on ppspd_pkg, ppspd_if, ppspd_divider and assert_macros.svh.
//
//  channel  | dir | payload                        | transfer
//  ---------+-----+--------------------------------+---------------------
//  in_ch    | in  | pulse_edge                     | valid & ready
//  out_ch   | out | speed_value, speed_updated     | valid & ready
//  cfg_ch   | in  | index (3b), data (24b)         | valid & ready (ready=1)
//
// Steps per item: without an update, accept, then load the result register; for an
// update, both divisions run one quotient bit per cycle in the shared divider, then
// the average; when the mean period reaches the limit the second division is skipped.
// One item is in work at a time; in_ch.ready returns once the result enters the
// output register, and a stalled out_ch holds ST_DONE. Synchronous reset loads
// defaults, clears speeds.
`include "assert_macros.svh"

module pulse_period_speedometer import ppspd_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  ppspd_in_if.sink    in_ch,
  ppspd_out_if.source out_ch,
  ppspd_cfg_if.sink   cfg_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_AVG,
    ST_DONE
  } state_t;

  // configuration registers
  logic                 metric_r;
  logic [TALLY_W-1:0]   pulses_r;
  logic [PERIOD_W-1:0]  spdcon_r;
  logic [PERIOD_W-1:0]  plimit_r;
  logic [23:0]          stall_r;
  logic [SPEED_W-1:0]   ceiling_r;

  // sequencer state and its next values
  state_t               state_r, state_nxt;
  logic [TALLY_W-1:0]   tally_r, tally_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [SPEED_W-1:0]   prev_r, prev_nxt;
  logic [SPEED_W-1:0]   shown_r, shown_nxt;
  logic                 pend_upd_r, pend_upd_nxt;
  logic [SCALED_W-1:0]  spd_r, spd_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0]   out_speed_r, out_speed_nxt;
  logic                 out_upd_r, out_upd_nxt;

  // per-item arithmetic
  logic                 in_xfer;
  logic [TALLY_W-1:0]   tally_new;
  logic [TIMER_BITS-1:0] elapsed_new;
  logic [TALLY_W-1:0]   threshold;
  logic [PERIOD_W-1:0]  period;
  logic [36:0]          product;
  logic [SCALED_W:0]    sum;
  logic [SCALED_W-1:0]  avg;
  logic [SPEED_W-1:0]   clamped;

  // divider hookup
  div_ctl_t             div_ctl;
  div_stat_t            div_stat;
  logic [DIV_DW-1:0]    div_dividend;
  logic [DIV_VW-1:0]    div_divisor;
  logic [DIV_DW-1:0]    div_quo;

  ppspd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // configuration: always ready, drop writes past the last register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r  <= 1'b0;
      pulses_r  <= RST_PULSES;
      spdcon_r  <= RST_SPDCON;
      plimit_r  <= RST_PLIMIT;
      stall_r   <= RST_STALL;
      ceiling_r <= RST_CEILING;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_METRIC:  metric_r  <= cfg_ch.data[0];
        CFG_PULSES:  pulses_r  <= cfg_ch.data[TALLY_W-1:0];
        CFG_SPDCON:  spdcon_r  <= cfg_ch.data[PERIOD_W-1:0];
        CFG_PLIMIT:  plimit_r  <= cfg_ch.data[PERIOD_W-1:0];
        CFG_STALL:   stall_r   <= cfg_ch.data[23:0];
        CFG_CEILING: ceiling_r <= cfg_ch.data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && (state_r == ST_IDLE);

  always_comb begin
    // count the edge first, then advance time; both saturate
    tally_new   = tally_r + TALLY_W'(in_ch.pulse_edge && (tally_r != TALLY_MAX));
    elapsed_new = elapsed_r + TIMER_BITS'(elapsed_r != '1);
    threshold   = (pulses_r == '0) ? TALLY_W'(1) : pulses_r;
    // a zero mean period counts as one
    period      = (div_quo == '0) ? PERIOD_W'(1) : div_quo[PERIOD_W-1:0];
    product     = 37'(div_quo[PERIOD_W-1:0]) * 37'(METRIC_Q16);
    sum         = {1'b0, spd_r} + (SCALED_W + 1)'(prev_r);
    avg         = sum[SCALED_W:1];
    clamped     = (avg > SCALED_W'(ceiling_r)) ? ceiling_r : avg[SPEED_W-1:0];
  end

  // first division: elapsed / count; second: constant / period, left-aligned
  always_comb begin
    if (state_r == ST_IDLE) begin
      div_dividend = elapsed_new;
      div_divisor  = DIV_VW'(tally_new);
    end else begin
      div_dividend = {spdcon_r, (DIV_DW - PERIOD_W)'(0)};
      div_divisor  = period;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    tally_nxt     = tally_r;
    elapsed_nxt   = elapsed_r;
    prev_nxt      = prev_r;
    shown_nxt     = shown_r;
    pend_upd_nxt  = pend_upd_r;
    spd_nxt       = spd_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_speed_nxt = out_speed_r;
    out_upd_nxt   = out_upd_r;
    div_ctl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          tally_nxt   = tally_new;
          elapsed_nxt = elapsed_new;
          if (tally_new >= threshold) begin
            div_ctl.start = 1'b1;
            div_ctl.steps = DIV_CW'(DIV_DW);
            state_nxt     = ST_DIV1;
          end else begin
            // stall: zero the shown speed, keep the previous one
            if (elapsed_new > TIMER_BITS'(stall_r)) begin
              shown_nxt = '0;
            end
            pend_upd_nxt = 1'b0;
            state_nxt    = ST_DONE;
          end
        end
      end
      ST_DIV1: begin
        if (div_stat.done) begin
          if (div_quo >= TIMER_BITS'(plimit_r)) begin
            // too slow: report zero and restart the window
            prev_nxt     = '0;
            shown_nxt    = '0;
            tally_nxt    = '0;
            elapsed_nxt  = '0;
            pend_upd_nxt = 1'b1;
            state_nxt    = ST_DONE;
          end else begin
            div_ctl.start = 1'b1;
            div_ctl.steps = DIV_CW'(PERIOD_W);
            state_nxt     = ST_DIV2;
          end
        end
      end
      ST_DIV2: begin
        if (div_stat.done) begin
          spd_nxt   = metric_r ? product[36:16] : SCALED_W'(div_quo[PERIOD_W-1:0]);
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        // average with the last speed, clamp, restart the window
        prev_nxt     = clamped;
        shown_nxt    = clamped;
        tally_nxt    = '0;
        elapsed_nxt  = '0;
        pend_upd_nxt = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = shown_r;
          out_upd_nxt   = pend_upd_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tally_r     <= '0;
      elapsed_r   <= '0;
      prev_r      <= '0;
      shown_r     <= '0;
      pend_upd_r  <= 1'b0;
      spd_r       <= '0;
      out_valid_r <= 1'b0;
      out_speed_r <= '0;
      out_upd_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tally_r     <= tally_nxt;
      elapsed_r   <= elapsed_nxt;
      prev_r      <= prev_nxt;
      shown_r     <= shown_nxt;
      pend_upd_r  <= pend_upd_nxt;
      spd_r       <= spd_nxt;
      out_valid_r <= out_valid_nxt;
      out_speed_r <= out_speed_nxt;
      out_upd_r   <= out_upd_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.speed_value   = out_speed_r;
  assign out_ch.speed_updated = out_upd_r;

  // the divider only runs or finishes while the sequencer waits on it
  `ASSERT_IMPL(a_div_owned, div_stat.busy || div_stat.done,
    state_r == ST_DIV1 || state_r == ST_DIV2, "divider active outside a division state")
  // an update restarts the window and stores the new speed as the last one
  `ASSERT_IMPL(a_upd_restart, state_r == ST_DONE && pend_upd_r,
    tally_r == '0 && elapsed_r == '0 && prev_r == shown_r, "update did not restart window")
  // a new result only appears out of the final state
  `ASSERT_CLK(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == ST_DONE),
    "result register loaded outside final state")

endmodule

@@ rtl/ppspd_divider.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ppspd_pkg for widths and the control and status structs.
module ppspd_divider import ppspd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctl_t          ctl,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_VW-1:0] divisor,
  output div_stat_t         stat,
  output logic [DIV_DW-1:0] quotient
);

  logic [DIV_DW-1:0] quo_r;
  logic [DIV_VW:0]   rem_r;
  logic [DIV_VW-1:0] dsr_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              done_r;
  logic [DIV_VW:0]   shifted;
  logic [DIV_VW:0]   trial;

  always_comb begin
    shifted = {rem_r[DIV_VW-1:0], quo_r[DIV_DW-1]};
    trial   = shifted - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        cnt_r <= ctl.steps;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CW'(1);
        if (cnt_r == DIV_CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift the dividend out at the top, quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DIV_DW-2:0], ~trial[DIV_VW]};
      rem_r <= trial[DIV_VW] ? shifted : trial;
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
